>>> sv/ksr_pkg.sv
// Shared constants, types and control structs of the k-space linear resampler.
package ksr_pkg;

  localparam int LINE_MAX       = 4096;
  localparam int MAX_PER_SAMPLE = 16;
  localparam int SAMPLE_BITS    = 16;
  localparam int FRACTION_BITS  = 16;
  localparam int TABLE_DEPTH    = LINE_MAX - 2;

  localparam int IDX_W  = 12;
  localparam int LEN_W  = 13;
  localparam int BUF_AW = $clog2(MAX_PER_SAMPLE);
  localparam int CNT_W  = BUF_AW + 1;
  localparam int COEF_W = IDX_W + FRACTION_BITS;
  localparam int PROD_W = (FRACTION_BITS + 1) + (SAMPLE_BITS + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register index taken from the word address.
  localparam logic REG_LINE_LENGTH = 1'b0;

  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(LINE_MAX);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2048);

  localparam logic [CNT_W-1:0] LIMIT_MID  = CNT_W'(MAX_PER_SAMPLE);
  localparam logic [CNT_W-1:0] LIMIT_LAST = CNT_W'(MAX_PER_SAMPLE - 1);

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRACTION_BITS - 1));

  // Input kind codes.
  localparam logic KIND_TABLE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic load;
    logic table_write;
    logic first_write;
    logic drop;
    logic mul;
    logic acc_write;
    logic tail;
    logic drain_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic first;
    logic scan_done;
    logic stop;
    logic full;
    logic has_results;
    logic out_free;
    logic drain_last;
  } ctrl_status_t;

  typedef struct packed {
    logic [IDX_W-1:0]       index;
    logic [SAMPLE_BITS-1:0] value;
    logic                   line_last;
    logic                   frame_last;
  } result_t;

endpackage

>>> sv/kspace_linear_resampler.sv
// Top level: configuration register, controller and datapath of the k-space resampler.
//
// Usage: the input channel (in_valid/in_ready) carries two kinds of transaction.
// A table transaction (kind 0) writes the left sample index and Q0.16 fraction of
// one inner output; the table is loaded before any line is sent. A sample
// transaction (kind 1) delivers the next raw sample of the current A-line.
// Output 0 and output L-1 pass samples through; inner outputs are interpolated and
// sent in order on the output channel (out_valid/out_ready) when their right sample
// arrives. line_length is written over the APB port while the block is idle.
// Timing: a table write completes in the idle state. A sample is loaded; then for
// each table entry the scan reads the coefficient and either stops at an entry whose
// right sample is still to come, drops it when the buffer is full, or multiplies and
// writes an inner output. The tail step then advances the line position, and each
// result moves from the result buffer into the output register. The table memory
// read and the registered multiply set the per-output cost.
// The next transaction is accepted while the last result still waits in the output
// register. A stalled receiver holds the drain; the input waits meanwhile.
// Reset clears the line position and pointer and sets line_length to 2048; the
// coefficient table is not cleared and must be written before use.
module kspace_linear_resampler (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   kind,
  input  logic [ksr_pkg::IDX_W-1:0]              coef_index,
  input  logic [ksr_pkg::IDX_W-1:0]              coef_left,
  input  logic [ksr_pkg::FRACTION_BITS-1:0]      coef_fraction,
  input  logic signed [ksr_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   frame_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ksr_pkg::IDX_W-1:0]              out_index,
  output logic signed [ksr_pkg::SAMPLE_BITS-1:0] value,
  output logic                                   line_last,
  output logic                                   frame_last,
  output logic                                   overrun,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ksr_pkg::ADDR_W-1:0]             paddr,
  input  logic [ksr_pkg::DATA_W-1:0]             pwdata,
  output logic [ksr_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready
);

  logic [ksr_pkg::LEN_W-1:0] line_length;
  logic                      reg_sel;
  ksr_pkg::ctrl_cmd_t        cmd;
  ksr_pkg::ctrl_status_t     status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= ksr_pkg::LEN_RESET;
    end else if (psel && penable && pwrite && (reg_sel == ksr_pkg::REG_LINE_LENGTH)) begin
      line_length <= pwdata[ksr_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    if (reg_sel == ksr_pkg::REG_LINE_LENGTH) begin
      prdata = {{(ksr_pkg::DATA_W - ksr_pkg::LEN_W){1'b0}}, line_length};
    end else begin
      prdata = '0;
    end
  end

  ksr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ksr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .coef_index    (coef_index),
    .coef_left     (coef_left),
    .coef_fraction (coef_fraction),
    .sample        (sample),
    .frame_end     (frame_end),
    .line_length   (line_length),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_index     (out_index),
    .value         (value),
    .line_last     (line_last),
    .frame_last    (frame_last),
    .overrun       (overrun)
  );

endmodule

>>> sv/ksr_datapath.sv
// Datapath: coefficient memory, line position state, interpolator and result buffer.
module ksr_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ksr_pkg::ctrl_cmd_t                     cmd,
  output ksr_pkg::ctrl_status_t                  status,
  input  logic [ksr_pkg::IDX_W-1:0]              coef_index,
  input  logic [ksr_pkg::IDX_W-1:0]              coef_left,
  input  logic [ksr_pkg::FRACTION_BITS-1:0]      coef_fraction,
  input  logic signed [ksr_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   frame_end,
  input  logic [ksr_pkg::LEN_W-1:0]              line_length,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [ksr_pkg::IDX_W-1:0]              out_index,
  output logic signed [ksr_pkg::SAMPLE_BITS-1:0] value,
  output logic                                   line_last,
  output logic                                   frame_last,
  output logic                                   overrun
);

  logic [ksr_pkg::COEF_W-1:0] coef_mem [ksr_pkg::TABLE_DEPTH];
  logic [ksr_pkg::COEF_W-1:0] coef_rd;

  logic signed [ksr_pkg::SAMPLE_BITS-1:0] prev;
  logic signed [ksr_pkg::SAMPLE_BITS-1:0] cur;
  logic                                   fe;
  logic [ksr_pkg::IDX_W-1:0]              pos;
  logic [ksr_pkg::IDX_W-1:0]              ptr;
  logic [ksr_pkg::CNT_W-1:0]              n;
  logic [ksr_pkg::BUF_AW-1:0]             rd;
  logic                                   dropped;
  logic signed [ksr_pkg::PROD_W-1:0]      prod;

  ksr_pkg::result_t result_buf [ksr_pkg::MAX_PER_SAMPLE];
  logic                        buf_we;
  logic [ksr_pkg::BUF_AW-1:0]  buf_waddr;
  ksr_pkg::result_t            buf_wdata;

  logic [ksr_pkg::LEN_W-1:0]              len_sat;
  logic [ksr_pkg::LEN_W-1:0]              len_m1;
  logic                                   last;
  logic [ksr_pkg::IDX_W-1:0]              ptr_m1;
  logic [ksr_pkg::IDX_W-1:0]              left;
  logic [ksr_pkg::FRACTION_BITS-1:0]      frac;
  logic signed [ksr_pkg::FRACTION_BITS:0] frac_s;
  logic signed [ksr_pkg::SAMPLE_BITS:0]   diff;
  logic signed [ksr_pkg::PROD_W-1:0]      round_sum;
  logic [ksr_pkg::SAMPLE_BITS-1:0]        interp;
  logic [ksr_pkg::CNT_W-1:0]              limit;

  // Line length is clamped to the supported range.
  always_comb begin
    if (line_length < ksr_pkg::LEN_MIN) begin
      len_sat = ksr_pkg::LEN_MIN;
    end else if (line_length > ksr_pkg::LEN_MAX) begin
      len_sat = ksr_pkg::LEN_MAX;
    end else begin
      len_sat = line_length;
    end
  end

  assign len_m1    = len_sat - ksr_pkg::LEN_W'(1);
  assign last      = {1'b0, pos} >= len_m1;
  assign ptr_m1    = ptr - ksr_pkg::IDX_W'(1);
  assign left      = coef_rd[ksr_pkg::COEF_W-1:ksr_pkg::FRACTION_BITS];
  assign frac      = coef_rd[ksr_pkg::FRACTION_BITS-1:0];
  assign frac_s    = {1'b0, frac};
  assign diff      = {cur[ksr_pkg::SAMPLE_BITS-1], cur} - {prev[ksr_pkg::SAMPLE_BITS-1], prev};
  // Adding one half then taking the high bits rounds half toward plus infinity.
  assign round_sum = prod + ksr_pkg::ROUND_HALF;
  assign interp    = prev + round_sum[ksr_pkg::FRACTION_BITS +: ksr_pkg::SAMPLE_BITS];
  // On the last sample of a line one buffer slot stays free for the pass-through.
  assign limit     = last ? ksr_pkg::LIMIT_LAST : ksr_pkg::LIMIT_MID;

  assign status.first       = (pos == '0);
  assign status.scan_done   = {1'b0, ptr} >= len_m1;
  assign status.stop        = !last && (left >= pos);
  assign status.full        = (n == limit);
  assign status.has_results = last || (n != '0);
  assign status.out_free    = !out_valid || out_ready;
  assign status.drain_last  = ({1'b0, rd} == n - ksr_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.table_write && (coef_index < ksr_pkg::IDX_W'(ksr_pkg::TABLE_DEPTH))) begin
      coef_mem[coef_index] <= {coef_left, coef_fraction};
    end
    coef_rd <= coef_mem[ptr_m1];
  end

  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = n[ksr_pkg::BUF_AW-1:0];
    buf_wdata = '{index: ptr, value: interp, line_last: 1'b0, frame_last: 1'b0};
    if (cmd.first_write) begin
      buf_we    = 1'b1;
      buf_waddr = '0;
      buf_wdata = '{index: '0, value: cur, line_last: 1'b0, frame_last: 1'b0};
    end else if (cmd.acc_write) begin
      buf_we = 1'b1;
    end else if (cmd.tail && last) begin
      buf_we    = 1'b1;
      buf_wdata = '{index: len_m1[ksr_pkg::IDX_W-1:0], value: cur, line_last: 1'b1,
                    frame_last: fe};
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      result_buf[buf_waddr] <= buf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= sample;
      fe  <= frame_end;
    end
    if (cmd.mul) begin
      prod <= frac_s * diff;
    end
    if (cmd.drain_load) begin
      out_index  <= result_buf[rd].index;
      value      <= result_buf[rd].value;
      line_last  <= result_buf[rd].line_last;
      frame_last <= result_buf[rd].frame_last;
      overrun    <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      pos       <= '0;
      ptr       <= '0;
      n         <= '0;
      rd        <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        n       <= '0;
        rd      <= '0;
        dropped <= 1'b0;
        if (ptr == '0) begin
          ptr <= ksr_pkg::IDX_W'(1);
        end
      end
      if (cmd.first_write) begin
        n    <= ksr_pkg::CNT_W'(1);
        prev <= cur;
        pos  <= ksr_pkg::IDX_W'(1);
        ptr  <= ksr_pkg::IDX_W'(1);
      end
      if (cmd.drop) begin
        ptr     <= ptr + ksr_pkg::IDX_W'(1);
        dropped <= 1'b1;
      end
      if (cmd.acc_write) begin
        n   <= n + ksr_pkg::CNT_W'(1);
        ptr <= ptr + ksr_pkg::IDX_W'(1);
      end
      if (cmd.tail) begin
        prev <= cur;
        if (last) begin
          n   <= n + ksr_pkg::CNT_W'(1);
          pos <= '0;
          ptr <= '0;
        end else begin
          pos <= pos + ksr_pkg::IDX_W'(1);
        end
      end
      if (cmd.drain_load) begin
        rd        <= rd + ksr_pkg::BUF_AW'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    n <= ksr_pkg::LIMIT_MID)
    else $error("result buffer count exceeds the burst limit");

  a_drop_at_limit: assert property (@(posedge clk) disable iff (rst)
    dropped |-> (n >= ksr_pkg::LIMIT_LAST))
    else $error("outputs dropped before the buffer was full");

  a_ptr_in_line: assert property (@(posedge clk) disable iff (rst)
    (pos != '0) |-> (ptr != '0))
    else $error("output pointer is zero inside a line");

  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_load |-> ({1'b0, rd} < n))
    else $error("drain reads past the filled part of the buffer");

endmodule

>>> sv/ksr_ctrl.sv
// Controller: sequences table writes, the per-sample table scan and the result drain.
module ksr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  kind,
  output logic                  in_ready,
  input  ksr_pkg::ctrl_status_t status,
  output ksr_pkg::ctrl_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_CHK   = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_TAIL  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (kind == ksr_pkg::KIND_SAMPLE) begin
            cmd.load   = 1'b1;
            state_next = ST_START;
          end else begin
            cmd.table_write = 1'b1;
          end
        end
      end
      // The coefficient read for the current pointer is issued in this state.
      ST_START: begin
        if (status.first) begin
          cmd.first_write = 1'b1;
          state_next      = ST_DRAIN;
        end else if (status.scan_done) begin
          state_next = ST_TAIL;
        end else begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (status.stop) begin
          state_next = ST_TAIL;
        end else if (status.full) begin
          cmd.drop   = 1'b1;
          state_next = ST_START;
        end else begin
          cmd.mul    = 1'b1;
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_write = 1'b1;
        state_next    = ST_START;
      end
      ST_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = status.has_results ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        if (status.out_free) begin
          cmd.drain_load = 1'b1;
          if (status.drain_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> tb/kspace_linear_resampler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the k-space linear resampler with its own interpolation model.
module kspace_linear_resampler_tb;

  localparam int SETTLE_CYCLES = 64;
  localparam int TOTAL_ITEMS   = 460;
  localparam int CALM_FROM     = 360;

  typedef enum int {MAP_SMOOTH, MAP_BUNCHED, MAP_SCRAMBLED} map_style_t;

  typedef struct {
    logic                                   kind;
    logic [ksr_pkg::IDX_W-1:0]              coef_index;
    logic [ksr_pkg::IDX_W-1:0]              coef_left;
    logic [ksr_pkg::FRACTION_BITS-1:0]      coef_fraction;
    logic signed [ksr_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   frame_end;
  } ksr_item_t;

  typedef struct {
    logic [ksr_pkg::IDX_W-1:0]              index;
    logic signed [ksr_pkg::SAMPLE_BITS-1:0] value;
    logic                                   line_last;
    logic                                   frame_last;
    logic                                   overrun;
  } ksr_out_t;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic                                   kind = 1'b0;
  logic [ksr_pkg::IDX_W-1:0]              coef_index = '0;
  logic [ksr_pkg::IDX_W-1:0]              coef_left = '0;
  logic [ksr_pkg::FRACTION_BITS-1:0]      coef_fraction = '0;
  logic signed [ksr_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic                                   frame_end = 1'b0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic [ksr_pkg::IDX_W-1:0]              out_index;
  logic signed [ksr_pkg::SAMPLE_BITS-1:0] value;
  logic                                   line_last;
  logic                                   frame_last;
  logic                                   overrun;
  logic                                   psel = 1'b0;
  logic                                   penable = 1'b0;
  logic                                   pwrite = 1'b0;
  logic [ksr_pkg::ADDR_W-1:0]             paddr = '0;
  logic [ksr_pkg::DATA_W-1:0]             pwdata = '0;
  logic [ksr_pkg::DATA_W-1:0]             prdata;
  logic                                   pready;

  // Model state.
  logic [ksr_pkg::LEN_W-1:0]         cfg_len = ksr_pkg::LEN_RESET;
  longint                            prev_s = 0;
  int                                line_pos = 0;
  int                                out_ptr = 0;
  logic [ksr_pkg::IDX_W-1:0]         left_tab [ksr_pkg::TABLE_DEPTH];
  logic [ksr_pkg::FRACTION_BITS-1:0] frac_tab [ksr_pkg::TABLE_DEPTH];

  ksr_item_t feed_q[$];
  ksr_out_t  resampled_q[$];
  ksr_item_t cur_item;
  bit        holding = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        in_odds = 0;
  int        out_odds = 0;
  int        fed = 0;
  int        mismatches = 0;
  int        table_writes = 0;
  int        samples_fed = 0;
  int        checked = 0;
  int        lines_seen = 0;
  int        overrun_seen = 0;

  kspace_linear_resampler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .coef_index(coef_index), .coef_left(coef_left),
    .coef_fraction(coef_fraction), .sample(sample), .frame_end(frame_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_index(out_index), .value(value), .line_last(line_last),
    .frame_last(frame_last), .overrun(overrun),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // a + f*(b-a), rounded half up; the arithmetic shift gives the floor.
  function automatic logic signed [ksr_pkg::SAMPLE_BITS-1:0] blend(
      input longint a, input longint b, input logic [ksr_pkg::FRACTION_BITS-1:0] f);
    longint fw;
    longint t;
    fw = f;
    t = fw * (b - a) + (longint'(1) <<< (ksr_pkg::FRACTION_BITS - 1));
    return ksr_pkg::SAMPLE_BITS'(a + (t >>> ksr_pkg::FRACTION_BITS));
  endfunction

  function automatic ksr_out_t make_out(input int idx,
                                        input logic signed [ksr_pkg::SAMPLE_BITS-1:0] v,
                                        input logic ll, input logic fl);
    ksr_out_t r;
    r.index = ksr_pkg::IDX_W'(idx);
    r.value = v;
    r.line_last = ll;
    r.frame_last = fl;
    r.overrun = 1'b0;
    return r;
  endfunction

  task automatic resample_item(input ksr_item_t it);
    ksr_out_t step_q[$];
    longint   s;
    int       len;
    int       cap;
    int       slot;
    bit       at_end;
    bit       dropped;
    if (it.kind == ksr_pkg::KIND_TABLE) begin
      table_writes++;
      if (it.coef_index < ksr_pkg::TABLE_DEPTH) begin
        left_tab[it.coef_index] = it.coef_left;
        frac_tab[it.coef_index] = it.coef_fraction;
      end
      return;
    end
    samples_fed++;
    s = it.sample;
    len = int'(cfg_len);
    if (len < 3)
      len = 3;
    if (len > ksr_pkg::LINE_MAX)
      len = ksr_pkg::LINE_MAX;
    dropped = 1'b0;
    if (line_pos == 0) begin
      step_q.push_back(make_out(0, it.sample, 1'b0, 1'b0));
      line_pos = 1;
      out_ptr = 1;
    end else begin
      at_end = line_pos >= len - 1;
      // On the last sample one slot stays free for the pass-through.
      cap = at_end ? ksr_pkg::MAX_PER_SAMPLE - 1 : ksr_pkg::MAX_PER_SAMPLE;
      while (out_ptr <= len - 2) begin
        slot = out_ptr - 1;
        if (!at_end && int'(left_tab[slot]) + 1 > line_pos)
          break;
        if (step_q.size() < cap)
          step_q.push_back(make_out(out_ptr, blend(prev_s, s, frac_tab[slot]), 1'b0, 1'b0));
        else
          dropped = 1'b1;
        out_ptr++;
      end
      if (at_end) begin
        step_q.push_back(make_out(len - 1, it.sample, 1'b1, it.frame_end));
        line_pos = 0;
        out_ptr = 0;
      end else begin
        line_pos++;
      end
    end
    prev_s = s;
    foreach (step_q[k]) begin
      step_q[k].overrun = dropped;
      resampled_q.push_back(step_q[k]);
    end
  endtask

  // Input side: one transaction held at a time, random bursts of idle cycles between some of them.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      holding = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resample_item(cur_item);
        holding = 1'b0;
      end
      if (!holding) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (feed_q.size() != 0) begin
          cur_item = feed_q.pop_front();
          holding = 1'b1;
          kind <= cur_item.kind;
          coef_index <= cur_item.coef_index;
          coef_left <= cur_item.coef_left;
          coef_fraction <= cur_item.coef_fraction;
          sample <= cur_item.sample;
          frame_end <= cur_item.frame_end;
          in_valid <= 1'b1;
          if (in_odds != 0 && $urandom_range(1, in_odds) == 1)
            in_gap = $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string field, input longint want_v, input longint got_v);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  // Output side: compare each transaction with the oldest predicted one.
  always @(posedge clk) begin
    ksr_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (resampled_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output, expected none, got index %0d value %0d",
                   $time, out_index, value);
        end else begin
          want = resampled_q.pop_front();
          checked++;
          if (out_index !== want.index)
            report_field("out_index", want.index, out_index);
          if (value !== want.value)
            report_field("value", want.value, value);
          if (line_last !== want.line_last)
            report_field("line_last", want.line_last, line_last);
          if (frame_last !== want.frame_last)
            report_field("frame_last", want.frame_last, frame_last);
          if (overrun !== want.overrun)
            report_field("overrun", want.overrun, overrun);
          if (want.line_last)
            lines_seen++;
          if (want.overrun)
            overrun_seen++;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_odds != 0 && $urandom_range(1, out_odds) == 1)
          out_gap = $urandom_range(1, 19);
      end
    end
  end

  task automatic push_coef(input int idx, input int left,
                           input logic [ksr_pkg::FRACTION_BITS-1:0] f);
    ksr_item_t it;
    it.kind = ksr_pkg::KIND_TABLE;
    it.coef_index = ksr_pkg::IDX_W'(idx);
    it.coef_left = ksr_pkg::IDX_W'(left);
    it.coef_fraction = f;
    it.sample = ksr_pkg::SAMPLE_BITS'($urandom);
    it.frame_end = 1'($urandom_range(0, 1));
    feed_q.push_back(it);
    fed++;
  endtask

  task automatic push_sample(input logic signed [ksr_pkg::SAMPLE_BITS-1:0] s, input logic fe);
    ksr_item_t it;
    it.kind = ksr_pkg::KIND_SAMPLE;
    it.coef_index = ksr_pkg::IDX_W'($urandom);
    it.coef_left = ksr_pkg::IDX_W'($urandom);
    it.coef_fraction = ksr_pkg::FRACTION_BITS'($urandom);
    it.sample = s;
    it.frame_end = fe;
    feed_q.push_back(it);
    fed++;
  endtask

  function automatic logic [ksr_pkg::FRACTION_BITS-1:0] pick_fraction();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return ksr_pkg::FRACTION_BITS'(1 << (ksr_pkg::FRACTION_BITS - 1));
      default: return ksr_pkg::FRACTION_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [ksr_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return '1;
      default: return ksr_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      2: return 8;
      default: return 20;
    endcase
  endfunction

  // Wait until every transaction is taken and every predicted output has arrived.
  task automatic wait_quiet();
    do
      @(negedge clk);
    while (feed_q.size() != 0 || holding || resampled_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input int raw);
    wait_quiet();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ksr_pkg::ADDR_W'(4 * ksr_pkg::REG_LINE_LENGTH);
    pwdata <= ksr_pkg::DATA_W'(raw);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_len = ksr_pkg::LEN_W'(raw);
  endtask

  task automatic build_table(input int len, input map_style_t style);
    int e;
    int lft;
    lft = 0;
    for (e = 0; e <= len - 3; e++) begin
      case (style)
        MAP_SMOOTH: lft += $urandom_range(0, 2);
        MAP_BUNCHED: if ($urandom_range(0, 7) == 0) lft += $urandom_range(1, 8);
        default: lft = $urandom_range(0, 4094);
      endcase
      if (style != MAP_SCRAMBLED && lft > len - 2)
        lft = len - 2;
      push_coef(e, lft, pick_fraction());
    end
  endtask

  // Stray table writes land only past this line's entries, sometimes on ignored indexes.
  task automatic send_line(input int len, input logic fe);
    int i;
    for (i = 0; i < len; i++) begin
      push_sample(pick_sample(), (i == len - 1) ? fe : ($urandom_range(0, 9) == 0));
      if ($urandom_range(0, 19) == 0)
        push_coef($urandom_range(len - 2, 4095), $urandom_range(0, 4094), pick_fraction());
    end
  endtask

  initial begin
    int len;
    int raw;
    int e;
    int k;
    int pick;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    in_odds = 4;
    out_odds = 4;

    // Shortest line, ignored table indexes, full-scale samples, frame end mid-line.
    set_length(3);
    push_coef(4095, 4094, 16'hFFFF);
    push_coef(4094, 4094, 16'hFFFF);
    push_coef(4093, 4094, 16'h0000);
    push_coef(0, 0, 16'hFFFF);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7FFF, 1'b1);
    push_sample(16'sh0000, 1'b1);
    // Left index beyond the line: the inner output waits for the last sample.
    push_coef(0, 4094, 16'h8000);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(-16'sd1, 1'b0);
    // Second entry points behind the first and comes out on the same sample.
    set_length(5);
    push_coef(0, 2, 16'h0000);
    push_coef(1, 0, 16'd12345);
    push_coef(2, 3, 16'hFFFF);
    send_line(5, 1'b1);
    // A length below the legal range acts as three.
    set_length(0);
    send_line(3, 1'b1);

    // Burst limit on the last sample, then in mid-line.
    set_length(18);
    for (e = 0; e < 16; e++)
      push_coef(e, 4094, pick_fraction());
    send_line(18, 1'b1);
    set_length(20);
    for (e = 0; e < 18; e++)
      push_coef(e, 2, pick_fraction());
    send_line(20, 1'b0);

    // Oversized length saturates; shrinking it mid-line ends the line early and
    // flushes the entries that were still waiting for their right sample.
    set_length(8191);
    for (e = 0; e < 3; e++)
      push_coef(e, 4000, pick_fraction());
    for (k = 0; k < 6; k++)
      push_sample(pick_sample(), 1'b0);
    set_length(5);
    push_sample(pick_sample(), 1'b1);

    while (fed < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) == 0 && fed < 300)
        len = $urandom_range(25, 48);
      else
        len = $urandom_range(3, 24);
      raw = len;
      if ($urandom_range(0, 9) == 0) begin
        len = 3;
        raw = $urandom_range(0, 3);
      end
      set_length(raw);
      if (fed >= CALM_FROM) begin
        in_odds = 0;
        out_odds = 0;
      end else begin
        in_odds = pick_odds();
        out_odds = pick_odds();
      end
      pick = $urandom_range(0, 19);
      if (pick < 12)
        build_table(len, MAP_SMOOTH);
      else if (pick < 17)
        build_table(len, MAP_BUNCHED);
      else
        build_table(len, MAP_SCRAMBLED);
      repeat ($urandom_range(1, 3)) send_line(len, 1'($urandom_range(0, 1)));
    end

    wait_quiet();
    $display("Fed %0d table writes and %0d samples over line lengths of 3 to 48 samples.",
             table_writes, samples_fed);
    $display("Checked %0d outputs over %0d A-lines, %0d of them flagged overrun.",
             checked, lines_seen, overrun_seen);
    if (mismatches == 0 && resampled_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: the resampler stopped moving transactions.");
    $display("TB_ERROR");
    $finish;
  end

endmodule
